// ===== sv/order_book_price_levels_top_macros.svh =====
// Assertion helpers for the price level table
`ifndef ORDER_BOOK_PRICE_LEVELS_TOP_MACROS_SVH
`define ORDER_BOOK_PRICE_LEVELS_TOP_MACROS_SVH

// same-cycle implication
`define OBPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OBPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/obpl_pkg.sv =====
`default_nettype none
package obpl_pkg;

	// cell commands
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_CMP    = 3'd1;
	localparam logic [2:0] OP_WRITE  = 3'd2;
	localparam logic [2:0] OP_INSERT = 3'd3;
	localparam logic [2:0] OP_REMOVE = 3'd4;

	// result status codes
	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_INSERTED  = 3'd1;
	localparam logic [2:0] ST_REDUCED   = 3'd2;
	localparam logic [2:0] ST_REMOVED   = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	// command broadcast along a chain of level cells
	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] price;
		logic [31:0] shares;
	} lvl_cmd_t;

endpackage
`default_nettype wire

// ===== sv/order_book_price_levels_top.sv =====
// A request is taken only in idle, then runs the compare, select and update
// states in order; compare, select and update each take one pass over the chain
// of level cells, and done is registered from the update state.
// Reset: arst_n clears the FSM, both level counts and done; level storage is
// left as is and only live levels are ever read. The receiver cannot stall.
`default_nettype none
`include "order_book_price_levels_top_macros.svh"
module order_book_price_levels_top #(
	parameter int LEVEL_DEPTH = 64,
	localparam int CNTW       = $clog2(LEVEL_DEPTH + 1)
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  wire              mode,
	input  wire              side,
	input  wire  [31:0]      price,
	input  wire  [31:0]      shares,
	output logic             done,
	output logic [2:0]       status,
	output logic [CNTW-1:0]  level_index,
	output logic [31:0]      level_shares,
	output logic [CNTW-1:0]  side_count
);
	import obpl_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_SEL  = 2'd2;
	localparam logic [1:0] S_UPD  = 2'd3;

	localparam logic [CNTW-1:0] DEPTH = CNTW'(LEVEL_DEPTH);

	logic [1:0]      state_q;
	logic            mode_q, side_q;
	logic [31:0]     price_q, shares_q;
	logic [CNTW-1:0] bid_cnt_q, ask_cnt_q;
	logic [CNTW-1:0] pos_q;
	logic            hit_q;
	logic [31:0]     hit_shares_q;
	logic            done_q;

	// chain wiring, one row per side
	logic [31:0] bid_p [LEVEL_DEPTH];
	logic [31:0] bid_s [LEVEL_DEPTH];
	logic [31:0] ask_p [LEVEL_DEPTH];
	logic [31:0] ask_s [LEVEL_DEPTH];
	logic        bid_bef [LEVEL_DEPTH];
	logic        bid_mat [LEVEL_DEPTH];
	logic        ask_bef [LEVEL_DEPTH];
	logic        ask_mat [LEVEL_DEPTH];

	lvl_cmd_t        upd_cmd;
	lvl_cmd_t        bid_cmd, ask_cmd;
	logic [CNTW-1:0] cnt_sel, cnt_next;
	logic [2:0]      st_next;
	logic [CNTW-1:0] idx_next;
	logic [31:0]     left_next;
	logic [CNTW-1:0] pos_c;
	logic            any_b, hit_c;
	logic [31:0]     hs_c;
	logic [32:0]     sum33;
	logic [31:0]     sat_sum;

	assign busy    = state_q != S_IDLE;
	assign done    = done_q;
	assign cnt_sel = side_q ? bid_cnt_q : ask_cnt_q;

	// request register and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bid_cnt_q <= '0;
			ask_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (state_q == S_UPD);
			case (state_q)
				S_IDLE: if (start) state_q <= S_CMP;
				S_CMP:  state_q <= S_SEL;
				S_SEL:  state_q <= S_UPD;
				S_UPD: begin
					state_q <= S_IDLE;
					if (side_q) bid_cnt_q <= cnt_next;
					else        ask_cnt_q <= cnt_next;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q   <= mode;
			side_q   <= side;
			price_q  <= price;
			shares_q <= shares;
		end
		if (state_q == S_SEL) begin
			pos_q        <= any_b ? pos_c : DEPTH;
			hit_q        <= hit_c;
			hit_shares_q <= hs_c;
		end
		if (state_q == S_UPD) begin
			status       <= st_next;
			level_index  <= idx_next;
			level_shares <= left_next;
			side_count   <= cnt_next;
		end
	end

	// locate the sorted boundary and the matching level on the chosen side
	always_comb begin
		logic prev;
		logic bef, mat, b;
		logic [31:0] sh;
		pos_c = '0;
		any_b = 1'b0;
		hit_c = 1'b0;
		hs_c  = '0;
		prev  = 1'b1;
		for (int i = 0; i < LEVEL_DEPTH; i++) begin
			bef = side_q ? bid_bef[i] : ask_bef[i];
			mat = side_q ? bid_mat[i] : ask_mat[i];
			sh  = side_q ? bid_s[i] : ask_s[i];
			b   = !bef && prev;
			prev = bef;
			pos_c = pos_c | (b ? CNTW'(i) : '0);
			any_b = any_b | b;
			hit_c = hit_c | mat;
			hs_c  = hs_c | (mat ? sh : '0);
		end
	end

	// update decision
	assign sum33   = {1'b0, hit_shares_q} + {1'b0, shares_q};
	assign sat_sum = sum33[32] ? '1 : sum33[31:0];

	always_comb begin
		upd_cmd.op     = OP_NONE;
		upd_cmd.price  = price_q;
		upd_cmd.shares = shares_q;
		cnt_next  = cnt_sel;
		st_next   = ST_NOT_FOUND;
		idx_next  = DEPTH;
		left_next = '0;
		if (!mode_q) begin
			if (hit_q) begin
				upd_cmd.op     = OP_WRITE;
				upd_cmd.shares = sat_sum;
				st_next   = ST_ADDED;
				idx_next  = pos_q;
				left_next = sat_sum;
			end else if (cnt_sel >= DEPTH) begin
				st_next = ST_FULL;
			end else begin
				upd_cmd.op = OP_INSERT;
				cnt_next   = cnt_sel + CNTW'(1);
				st_next    = ST_INSERTED;
				idx_next   = pos_q;
				left_next  = shares_q;
			end
		end else if (hit_q) begin
			idx_next = pos_q;
			if (hit_shares_q <= shares_q) begin
				upd_cmd.op = OP_REMOVE;
				cnt_next   = cnt_sel - CNTW'(1);
				st_next    = ST_REMOVED;
			end else begin
				upd_cmd.op     = OP_WRITE;
				upd_cmd.shares = hit_shares_q - shares_q;
				st_next        = ST_REDUCED;
				left_next      = hit_shares_q - shares_q;
			end
		end
	end

	// broadcast: compare goes to both rows, updates to the chosen row only
	always_comb begin
		bid_cmd = upd_cmd;
		ask_cmd = upd_cmd;
		if (state_q == S_CMP) begin
			bid_cmd.op = OP_CMP;
			ask_cmd.op = OP_CMP;
		end else if (state_q == S_UPD) begin
			if (side_q) ask_cmd.op = OP_NONE;
			else        bid_cmd.op = OP_NONE;
		end else begin
			bid_cmd.op = OP_NONE;
			ask_cmd.op = OP_NONE;
		end
	end

	// level cell rows
	for (genvar g = 0; g < LEVEL_DEPTH; g++) begin : g_lvl
		logic [31:0] bl_p, bl_s, br_p, br_s, al_p, al_s, ar_p, ar_s;
		if (g == 0) begin : g_first
			assign bl_p = '0;
			assign bl_s = '0;
			assign al_p = '0;
			assign al_s = '0;
		end else begin : g_mid_l
			assign bl_p = bid_p[g-1];
			assign bl_s = bid_s[g-1];
			assign al_p = ask_p[g-1];
			assign al_s = ask_s[g-1];
		end
		if (g == LEVEL_DEPTH - 1) begin : g_last
			assign br_p = '0;
			assign br_s = '0;
			assign ar_p = '0;
			assign ar_s = '0;
		end else begin : g_mid_r
			assign br_p = bid_p[g+1];
			assign br_s = bid_s[g+1];
			assign ar_p = ask_p[g+1];
			assign ar_s = ask_s[g+1];
		end

		obpl_cell #(.CNTW(CNTW), .IDX(g), .IS_BID(1'b1)) u_bid (
			.clk          (clk),
			.cmd          (bid_cmd),
			.pos          (pos_q),
			.count        (bid_cnt_q),
			.left_price   (bl_p),
			.left_shares  (bl_s),
			.right_price  (br_p),
			.right_shares (br_s),
			.price_q      (bid_p[g]),
			.shares_q     (bid_s[g]),
			.before_q     (bid_bef[g]),
			.match_q      (bid_mat[g])
		);

		obpl_cell #(.CNTW(CNTW), .IDX(g), .IS_BID(1'b0)) u_ask (
			.clk          (clk),
			.cmd          (ask_cmd),
			.pos          (pos_q),
			.count        (ask_cnt_q),
			.left_price   (al_p),
			.left_shares  (al_s),
			.right_price  (ar_p),
			.right_shares (ar_s),
			.price_q      (ask_p[g]),
			.shares_q     (ask_s[g]),
			.before_q     (ask_bef[g]),
			.match_q      (ask_mat[g])
		);
	end

	// checks
	`OBPL_ASSERT_NEXT(a_upd_done, clk, arst_n, state_q == S_UPD, done_q && !busy, "no done beat")
	`OBPL_ASSERT_NOW(a_cnt_range, clk, arst_n, 1'b1, bid_cnt_q <= DEPTH && ask_cnt_q <= DEPTH, "bad count")
	`OBPL_ASSERT_NOW(a_idx_range, clk, arst_n, done_q, level_index <= DEPTH && side_count <= DEPTH, "bad index")

endmodule
`default_nettype wire

// ===== sv/obpl_cell.sv =====
`default_nettype none
module obpl_cell #(
	parameter int CNTW   = 7,
	parameter int IDX    = 0,
	parameter bit IS_BID = 1'b1
) (
	input  wire                   clk,
	input  obpl_pkg::lvl_cmd_t    cmd,
	input  wire  [CNTW-1:0]       pos,
	input  wire  [CNTW-1:0]       count,
	input  wire  [31:0]           left_price,
	input  wire  [31:0]           left_shares,
	input  wire  [31:0]           right_price,
	input  wire  [31:0]           right_shares,
	output logic [31:0]           price_q,
	output logic [31:0]           shares_q,
	output logic                  before_q,
	output logic                  match_q
);
	import obpl_pkg::*;

	localparam logic [CNTW-1:0] MY_IDX = CNTW'(IDX);

	logic valid;
	logic ahead;

	// level is live when it sits below the side's count
	assign valid = MY_IDX < count;
	assign ahead = IS_BID ? (price_q > cmd.price) : (price_q < cmd.price);

	// level storage and compare flags; shifts take a neighbor's level
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CMP: begin
				before_q <= valid && ahead;
				match_q  <= valid && (price_q == cmd.price);
			end
			OP_WRITE: begin
				if (MY_IDX == pos) begin
					price_q  <= cmd.price;
					shares_q <= cmd.shares;
				end
			end
			OP_INSERT: begin
				if (MY_IDX == pos) begin
					price_q  <= cmd.price;
					shares_q <= cmd.shares;
				end else if (MY_IDX > pos) begin
					price_q  <= left_price;
					shares_q <= left_shares;
				end
			end
			OP_REMOVE: begin
				if (MY_IDX >= pos) begin
					price_q  <= right_price;
					shares_q <= right_shares;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
